FILE: design/rtu_pkg.sv
// Package for the route table update core: constants, status codes and
// the structs shared by the front end, the table engine and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rtu_pkg;

    localparam int RTU_TABLE_ENTRIES = 256;
    localparam int RTU_QUEUE_DEPTH   = 2;
    localparam logic [15:0] RTU_HOLD_RESET = 16'd60;
    localparam logic [4:0]  RTU_INFINITY   = 5'd16;
    localparam logic [7:0]  RTU_MAX_LEN    = 8'd128;

    typedef enum logic [1:0] {
        MODE_ROUTE = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_SWEEP = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ROUTE  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SWEEP  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_REJECTED      = 4'd0,
        ST_WORSE         = 4'd1,
        ST_REFRESHED     = 4'd2,
        ST_IMPROVED      = 4'd3,
        ST_POISONED      = 4'd4,
        ST_INSTALLED     = 4'd5,
        ST_FULL          = 4'd6,
        ST_NOT_INSTALLED = 4'd7,
        ST_TICK          = 4'd8,
        ST_SWEEP_DONE    = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_SCAN  = 3'd2,
        S_APPLY = 3'd3,
        S_EMIT  = 3'd4
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] pfx_high;
        logic [63:0] pfx_low;
        logic [7:0]  pfx_len;
        logic [4:0]  metric;
        logic        adv_inf;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [7:0]  port;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [63:0] pfx_high;
        logic [63:0] pfx_low;
        logic [7:0]  pfx_len;
        logic [4:0]  metric;
        logic [63:0] hop_high;
        logic [63:0] hop_low;
        logic [7:0]  hop_port;
        logic [31:0] touched;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot;
        logic [8:0]  expired;
        logic [8:0]  removed;
    } t_result;

endpackage
`default_nettype wire

FILE: design/rtu_ifs.sv
// Channel interfaces of the route table update core: route input,
// result output and hold time configuration. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [7:0]  prefix_length;
    logic [7:0]  route_metric;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [7:0]  arrival_port;
    modport source (output valid, mode, prefix_high, prefix_low, prefix_length,
                    route_metric, source_high, source_low, arrival_port,
                    input ready);
    modport sink (input valid, mode, prefix_high, prefix_low, prefix_length,
                  route_metric, source_high, source_low, arrival_port,
                  output ready);
endinterface

interface rtu_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] entry_slot;
    logic [8:0] expired_count;
    logic [8:0] removed_count;
    modport source (output valid, status, entry_slot, expired_count, removed_count,
                    input ready);
    modport sink (input valid, status, entry_slot, expired_count, removed_count,
                  output ready);
endinterface

interface rtu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: design/rtu_front.sv
// Front end: accepts input transactions, checks and classifies them and
// queues commands for the table engine. Depends on rtu_pkg and rtu_ifs.
`timescale 1ns / 1ps
`default_nettype none
module rtu_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    rtu_in_if.sink          i_in,
    output rtu_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  wire             i_cmd_pop
);
    import rtu_pkg::*;

    localparam int QAW = (RTU_QUEUE_DEPTH > 1) ? $clog2(RTU_QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(RTU_QUEUE_DEPTH + 1);

    t_cmd           r_q [RTU_QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    t_cmd           cmd;
    logic           push;
    logic           pop;
    logic           bad;

    always_comb begin
        bad = (i_in.route_metric == 8'd0) || (i_in.route_metric > 8'(RTU_INFINITY))
            || (i_in.prefix_length > RTU_MAX_LEN) || (i_in.prefix_high[63:56] == 8'hff);
        cmd.pfx_high = i_in.prefix_high;
        cmd.pfx_low  = i_in.prefix_low;
        cmd.pfx_len  = i_in.prefix_length;
        cmd.metric   = i_in.route_metric[4:0] + 5'd1;
        cmd.adv_inf  = (i_in.route_metric == 8'(RTU_INFINITY));
        cmd.src_high = i_in.source_high;
        cmd.src_low  = i_in.source_low;
        cmd.port     = i_in.arrival_port;
        case (t_mode'(i_in.mode))
            MODE_ROUTE: cmd.kind = bad ? KIND_REJECT : KIND_ROUTE;
            MODE_TICK:  cmd.kind = KIND_TICK;
            default:    cmd.kind = KIND_SWEEP;
        endcase
    end

    assign i_in.ready  = (r_cnt != QCW'(RTU_QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready && (t_mode'(i_in.mode) != MODE_NONE);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QAW'(RTU_QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QAW'(RTU_QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

endmodule
`default_nettype wire

FILE: design/rtu_back.sv
// Table engine: holds the route table memory, the clock and the hold time,
// and carries out queued commands, scanning the table for route and sweep
// commands. Depends on rtu_pkg and rtu_ifs.
`timescale 1ns / 1ps
`default_nettype none
module rtu_back #(
    parameter int TABLE_ENTRIES = rtu_pkg::RTU_TABLE_ENTRIES
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  rtu_pkg::t_cmd   i_cmd,
    input  wire             i_cmd_valid,
    output logic            o_cmd_pop,
    rtu_cfg_if.sink         i_cfg,
    rtu_out_if.source       o_out
);
    import rtu_pkg::*;

    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW   = IDXW + 1;

    t_entry            mem [TABLE_ENTRIES];
    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_chk_vld, n_chk_vld;
    logic [IDXW-1:0]   r_chk_idx, n_chk_idx;
    t_cmd              r_cmd, n_cmd;
    logic              r_hit_fnd, n_hit_fnd;
    logic [IDXW-1:0]   r_hit_idx, n_hit_idx;
    t_entry            r_hit, n_hit;
    logic              r_free_fnd, n_free_fnd;
    logic [IDXW-1:0]   r_free_idx, n_free_idx;
    logic [8:0]        r_exp, n_exp;
    logic [8:0]        r_rem, n_rem;
    logic [31:0]       r_time, n_time;
    logic [15:0]       r_hold;
    t_entry            r_rd;
    t_result           r_res, n_res;
    logic              r_out_vld;
    t_result           r_out;
    logic              we;
    logic [IDXW-1:0]   wa;
    t_entry            wd;
    logic [IDXW-1:0]   rd_addr;
    logic [31:0]       age;
    logic [17:0]       expire_at;
    logic [16:0]       remove_at;
    logic              scan_done;
    logic              out_free;
    logic [IDXW+7:0]   hit_ext;
    logic [IDXW+7:0]   free_ext;
    t_entry            upd;

    assign i_cfg.ready = 1'b1;
    assign expire_at   = {1'b0, r_hold, 1'b0} + {2'b0, r_hold};
    assign remove_at   = {r_hold, 1'b0};
    assign rd_addr     = r_cnt[IDXW-1:0];
    assign age         = r_time - r_rd.touched;
    assign scan_done   = (r_cnt == CW'(TABLE_ENTRIES)) && !r_chk_vld;
    assign out_free    = !r_out_vld || o_out.ready;
    assign hit_ext     = {8'd0, r_hit_idx};
    assign free_ext    = {8'd0, r_free_idx};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == KIND_TICK || i_cmd.kind == KIND_REJECT) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_cmd      = r_cmd;
        n_hit_fnd  = r_hit_fnd;
        n_hit_idx  = r_hit_idx;
        n_hit      = r_hit;
        n_free_fnd = r_free_fnd;
        n_free_idx = r_free_idx;
        n_exp      = r_exp;
        n_rem      = r_rem;
        n_time     = r_time;
        n_res      = r_res;
        o_cmd_pop  = 1'b0;
        we         = 1'b0;
        wa         = r_chk_idx;
        wd         = r_rd;
        upd        = r_hit;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                wa    = r_cnt[IDXW-1:0];
                wd    = '0;
                n_cnt = r_cnt + 1'b1;
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_cnt      = '0;
                    n_chk_vld  = 1'b0;
                    n_hit_fnd  = 1'b0;
                    n_free_fnd = 1'b0;
                    n_exp      = '0;
                    n_rem      = '0;
                    n_res      = '{ST_REJECTED, 8'd0, 9'd0, 9'd0};
                    if (i_cmd.kind == KIND_TICK) begin
                        n_time       = r_time + 32'd1;
                        n_res.status = ST_TICK;
                    end
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(TABLE_ENTRIES)) begin
                    n_cnt     = r_cnt + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = rd_addr;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    if (r_cmd.kind == KIND_SWEEP) begin
                        if (r_rd.valid && r_rd.metric < RTU_INFINITY) begin
                            if (age >= {14'd0, expire_at}) begin
                                we         = 1'b1;
                                wd.metric  = RTU_INFINITY;
                                wd.touched = r_time;
                                n_exp      = r_exp + 9'd1;
                            end
                        end else if (r_rd.valid && r_rd.metric == RTU_INFINITY) begin
                            if (age >= {15'd0, remove_at}) begin
                                we       = 1'b1;
                                wd.valid = 1'b0;
                                n_rem    = r_rem + 9'd1;
                            end
                        end
                    end else begin
                        if (r_rd.valid && !r_hit_fnd && r_rd.pfx_high == r_cmd.pfx_high
                            && r_rd.pfx_low == r_cmd.pfx_low
                            && r_rd.pfx_len == r_cmd.pfx_len) begin
                            n_hit_fnd = 1'b1;
                            n_hit_idx = r_chk_idx;
                            n_hit     = r_rd;
                        end
                        if (!r_rd.valid && !r_free_fnd) begin
                            n_free_fnd = 1'b1;
                            n_free_idx = r_chk_idx;
                        end
                    end
                end
            end
            S_APPLY: begin
                if (r_cmd.kind == KIND_SWEEP) begin
                    n_res = '{ST_SWEEP_DONE, 8'd0, r_exp, r_rem};
                end else if (r_hit_fnd) begin
                    wa    = r_hit_idx;
                    n_res = '{ST_WORSE, hit_ext[7:0], 9'd0, 9'd0};
                    if (r_hit.metric >= r_cmd.metric) begin
                        we           = 1'b1;
                        upd.touched  = r_time;
                        n_res.status = ST_REFRESHED;
                        if (r_cmd.metric < r_hit.metric) begin
                            upd.metric   = r_cmd.metric;
                            upd.hop_high = r_cmd.src_high;
                            upd.hop_low  = r_cmd.src_low;
                            upd.hop_port = r_cmd.port;
                            n_res.status = ST_IMPROVED;
                        end
                    end else if (r_cmd.adv_inf && r_hit.hop_high == r_cmd.src_high
                                 && r_hit.hop_low == r_cmd.src_low
                                 && r_hit.metric < RTU_INFINITY) begin
                        we           = 1'b1;
                        upd.touched  = r_time;
                        upd.metric   = RTU_INFINITY;
                        n_res.status = ST_POISONED;
                    end
                    wd = upd;
                end else if (r_cmd.metric >= RTU_INFINITY) begin
                    n_res = '{ST_NOT_INSTALLED, 8'd0, 9'd0, 9'd0};
                end else if (r_free_fnd) begin
                    we    = 1'b1;
                    wa    = r_free_idx;
                    wd    = '{1'b1, r_cmd.pfx_high, r_cmd.pfx_low, r_cmd.pfx_len,
                              r_cmd.metric, r_cmd.src_high, r_cmd.src_low,
                              r_cmd.port, r_time};
                    n_res = '{ST_INSTALLED, free_ext[7:0], 9'd0, 9'd0};
                end else begin
                    n_res = '{ST_FULL, 8'd0, 9'd0, 9'd0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_cmd      <= n_cmd;
        r_hit_idx  <= n_hit_idx;
        r_hit      <= n_hit;
        r_free_idx <= n_free_idx;
        r_exp      <= n_exp;
        r_rem      <= n_rem;
        r_res      <= n_res;
        if (r_state == S_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_chk_vld  <= 1'b0;
            r_hit_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_time     <= '0;
            r_hold     <= RTU_HOLD_RESET;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_chk_vld  <= n_chk_vld;
            r_hit_fnd  <= n_hit_fnd;
            r_free_fnd <= n_free_fnd;
            r_time     <= n_time;
            if (i_cfg.valid) begin
                r_hold <= i_cfg.data;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out.status;
    assign o_out.entry_slot    = r_out.slot;
    assign o_out.expired_count = r_out.expired;
    assign o_out.removed_count = r_out.removed;

endmodule
`default_nettype wire

FILE: design/ripng_route_table_update_core.sv
// Top level of the route table update core: front end, command queue and
// table engine. Depends on rtu_pkg, rtu_ifs, rtu_front and rtu_back.
//
// Route, tick and sweep transactions enter on i_in; mode 3 is taken and
// dropped. Each other transaction gives one result transaction on o_out,
// in order. The user must write the hold time on i_cfg only while the
// block is idle; the block itself does not enforce this. A rejected or
// tick command passes from the queue through the engine's emit state into
// the output register; a route or sweep command first scans the whole
// table through the single read port of the table memory, which is read
// one entry per cycle, and then passes through the apply and emit states.
// The engine takes one command at a time. The front end queues two
// commands, so input keeps flowing until the queue is full while the
// engine works or while a result waits in the output register. After reset
// the table memory is cleared one entry per cycle; transactions queue but
// are not executed until the clearing is done. When the receiver stalls,
// the result is held and the engine waits before starting the next command.
`timescale 1ns / 1ps
`default_nettype none
module ripng_route_table_update_core #(
    parameter int TABLE_ENTRIES = rtu_pkg::RTU_TABLE_ENTRIES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rtu_in_if.sink      i_in,
    rtu_cfg_if.sink     i_cfg,
    rtu_out_if.source   o_out
);
    import rtu_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    rtu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    rtu_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.status <= 4'(ST_SWEEP_DONE))
        else $error("Result status out of range.");

    a_route_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != 4'(ST_SWEEP_DONE)
        |-> o_out.expired_count == 9'd0 && o_out.removed_count == 9'd0)
        else $error("Counts set on a non-sweep result.");

    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == 4'(ST_REJECTED) || o_out.status == 4'(ST_FULL)
        || o_out.status == 4'(ST_NOT_INSTALLED) || o_out.status == 4'(ST_TICK)
        || o_out.status == 4'(ST_SWEEP_DONE)) |-> o_out.entry_slot == 8'd0)
        else $error("Slot set on a result that touches no entry.");

endmodule
`default_nettype wire

FILE: tb/sv/ripng_route_table_update_core_tb.sv
// Testbench for the route table update core: drives route, tick and sweep
// transactions, predicts each result from its own table model and checks it.
// Depends on rtu_pkg, rtu_ifs and ripng_route_table_update_core.
`timescale 1ns / 1ps
module ripng_route_table_update_core_tb;
    import rtu_pkg::*;

    localparam int ENTRIES = 256;
    localparam int SCAN_CYCLES = ENTRIES + 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rtu_in_if  in_ch();
    rtu_out_if out_ch();
    rtu_cfg_if cfg_ch();

    ripng_route_table_update_core #(.TABLE_ENTRIES(ENTRIES)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .i_cfg(cfg_ch.sink),
        .o_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        t_mode       mode;
        logic [63:0] ph;
        logic [63:0] pl;
        logic [7:0]  len;
        logic [7:0]  metric;
        logic [63:0] sh;
        logic [63:0] sl;
        logic [7:0]  port;
    } t_route_item;

    // Table copy kept by the predictor.
    logic        tbl_valid [ENTRIES];
    logic [63:0] tbl_ph [ENTRIES];
    logic [63:0] tbl_pl [ENTRIES];
    logic [7:0]  tbl_len [ENTRIES];
    logic [4:0]  tbl_metric [ENTRIES];
    logic [63:0] tbl_hh [ENTRIES];
    logic [63:0] tbl_hl [ENTRIES];
    logic [7:0]  tbl_port [ENTRIES];
    logic [31:0] tbl_time [ENTRIES];
    logic [31:0] now_ticks;
    logic [15:0] hold_ticks;

    t_result pending_results[$];
    int      error_count = 0;
    int      result_count = 0;
    int      items_sent = 0;
    bit      in_idle_en = 1'b1;
    bit      out_idle_en = 1'b1;
    bit      out_hold = 1'b0;
    int      status_seen [10];

    // Known prefixes reused so that existing-entry paths are reached.
    logic [63:0] known_ph [16];
    logic [63:0] known_pl [16];
    logic [7:0]  known_len [16];
    logic [63:0] known_sh [4];
    logic [63:0] known_sl [4];

    function automatic t_result route_outcome(t_route_item it);
        t_result r;
        logic [4:0] m;
        r = '{status: ST_REJECTED, slot: 8'd0, expired: 9'd0, removed: 9'd0};
        if (it.metric < 8'd1 || it.metric > 8'd16 || it.len > 8'd128 ||
            it.ph[63:56] == 8'hff) begin
            return r;
        end
        m = it.metric[4:0] + 5'd1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_ph[i] == it.ph && tbl_pl[i] == it.pl &&
                tbl_len[i] == it.len) begin
                r.slot = i[7:0];
                r.status = ST_WORSE;
                if (tbl_metric[i] >= m) begin
                    tbl_time[i] = now_ticks;
                    r.status = ST_REFRESHED;
                    if (m < tbl_metric[i]) begin
                        tbl_metric[i] = m;
                        tbl_hh[i] = it.sh;
                        tbl_hl[i] = it.sl;
                        tbl_port[i] = it.port;
                        r.status = ST_IMPROVED;
                    end
                end else if (it.metric == 8'd16 && tbl_hh[i] == it.sh &&
                             tbl_hl[i] == it.sl && tbl_metric[i] < 5'd16) begin
                    tbl_time[i] = now_ticks;
                    tbl_metric[i] = 5'd16;
                    r.status = ST_POISONED;
                end
                return r;
            end
        end
        if (m >= 5'd16) begin
            r.status = ST_NOT_INSTALLED;
            return r;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_ph[i] = it.ph;
                tbl_pl[i] = it.pl;
                tbl_len[i] = it.len;
                tbl_metric[i] = m;
                tbl_hh[i] = it.sh;
                tbl_hl[i] = it.sl;
                tbl_port[i] = it.port;
                tbl_time[i] = now_ticks;
                r.status = ST_INSTALLED;
                r.slot = i[7:0];
                return r;
            end
        end
        r.status = ST_FULL;
        return r;
    endfunction

    function automatic t_result sweep_outcome();
        t_result r;
        logic [31:0] expire_at;
        logic [31:0] remove_at;
        logic [31:0] age;
        expire_at = 32'd3 * hold_ticks;
        remove_at = 32'd2 * hold_ticks;
        r = '{status: ST_SWEEP_DONE, slot: 8'd0, expired: 9'd0, removed: 9'd0};
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                age = now_ticks - tbl_time[i];
                if (tbl_metric[i] < 5'd16) begin
                    if (age >= expire_at) begin
                        tbl_metric[i] = 5'd16;
                        tbl_time[i] = now_ticks;
                        r.expired++;
                    end
                end else if (tbl_metric[i] == 5'd16 && age >= remove_at) begin
                    tbl_valid[i] = 1'b0;
                    r.removed++;
                end
            end
        end
        return r;
    endfunction

    function automatic void predict_table_update(t_route_item it);
        t_result r;
        case (it.mode)
            MODE_ROUTE: begin
                r = route_outcome(it);
                pending_results.insert(pending_results.size(), r);
            end
            MODE_TICK: begin
                now_ticks = now_ticks + 32'd1;
                r = '{status: ST_TICK, slot: 8'd0, expired: 9'd0, removed: 9'd0};
                pending_results.insert(pending_results.size(), r);
            end
            MODE_SWEEP: begin
                r = sweep_outcome();
                pending_results.insert(pending_results.size(), r);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input t_route_item it);
        int gap;
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.prefix_high <= it.ph;
        in_ch.prefix_low <= it.pl;
        in_ch.prefix_length <= it.len;
        in_ch.route_metric <= it.metric;
        in_ch.source_high <= it.sh;
        in_ch.source_low <= it.sl;
        in_ch.arrival_port <= it.port;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_table_update(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SCAN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_hold(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        hold_ticks = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_route_item make_route(logic [63:0] ph, logic [63:0] pl,
                                               logic [7:0] len, logic [7:0] metric,
                                               logic [63:0] sh, logic [63:0] sl,
                                               logic [7:0] port);
        t_route_item it;
        it = '{mode: MODE_ROUTE, ph: ph, pl: pl, len: len, metric: metric,
               sh: sh, sl: sl, port: port};
        return it;
    endfunction

    function automatic t_route_item make_op(t_mode mode);
        t_route_item it;
        it = '{mode: mode, ph: {$urandom, $urandom}, pl: {$urandom, $urandom},
               len: 8'($urandom), metric: 8'($urandom), sh: {$urandom, $urandom},
               sl: {$urandom, $urandom}, port: 8'($urandom)};
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_route_item random_item(int prefix_span);
        t_route_item it;
        int k;
        int h;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return make_op(MODE_TICK);
        if (pick < 11) return make_op(MODE_SWEEP);
        if (pick < 12) return make_op(MODE_NONE);
        k = $urandom_range(0, prefix_span - 1);
        h = $urandom_range(0, 3);
        it = make_route(known_ph[k], known_pl[k], known_len[k],
                        8'($urandom_range(1, 16)), known_sh[h], known_sl[h],
                        8'($urandom));
        if (pick < 22) begin
            it.ph = rand64();
            it.pl = rand64();
            it.len = 8'($urandom);
            it.metric = 8'($urandom);
            it.sh = rand64();
            it.sl = rand64();
        end else if (pick < 30) begin
            it.metric = 8'd16;
        end
        return it;
    endfunction

    task automatic test_directed_routes();
        logic [63:0] a;
        logic [63:0] b;
        a = 64'h2001_0db8_0000_0001;
        b = 64'h0000_0000_0000_0000;
        send_item(make_route(a, b, 8'd64, 8'd0, a, b, 8'd0));
        send_item(make_route(a, b, 8'd64, 8'd17, a, b, 8'd0));
        send_item(make_route(a, b, 8'd64, 8'd255, a, b, 8'd0));
        send_item(make_route(a, b, 8'd129, 8'd3, a, b, 8'd0));
        send_item(make_route(a, b, 8'd255, 8'd3, a, b, 8'd0));
        send_item(make_route(64'hff02_0000_0000_0000, b, 8'd16, 8'd3, a, b, 8'd0));
        send_item(make_route(64'hfeff_ffff_ffff_ffff, '1, 8'd128, 8'd5, '1, '1, 8'hff));
        send_item(make_route(a, b, 8'd64, 8'd15, a, b, 8'd1));
        send_item(make_route(a, b, 8'd64, 8'd16, a, b, 8'd1));
        send_item(make_route(b, b, 8'd0, 8'd1, b, b, 8'd0));
        send_item(make_route(b, b, 8'd0, 8'd1, a, a, 8'd2));
        send_item(make_route(b, b, 8'd0, 8'd4, a, a, 8'd2));
        send_item(make_route(b, b, 8'd0, 8'd16, b, b, 8'd2));
        send_item(make_route(b, b, 8'd0, 8'd16, a, a, 8'd2));
        send_item(make_route(b, b, 8'd0, 8'd16, a, a, 8'd2));
        send_item(make_route(b, b, 8'd0, 8'd1, a, a, 8'd3));
        send_item(make_route(b, b, 8'd0, 8'd2, b, b, 8'd3));
        send_item(make_op(MODE_NONE));
        send_item(make_op(MODE_TICK));
        send_item(make_op(MODE_SWEEP));
        wait_drained();
    endtask

    task automatic test_aging(input logic [15:0] hold, input int ticks);
        write_hold(hold);
        for (int i = 0; i < ticks; i++) begin
            send_item(make_op(MODE_TICK));
            if (i % 3 == 0) send_item(make_op(MODE_SWEEP));
        end
        send_item(make_op(MODE_SWEEP));
        send_item(make_op(MODE_SWEEP));
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < ENTRIES + 3; i++) begin
            send_item(make_route({32'h3000_0000, 32'(i)}, rand64(), 8'd128,
                                 8'($urandom_range(1, 14)), rand64(), rand64(), 8'(i)));
        end
        send_item(make_route(64'h3fff_0000_0000_0000, '0, 8'd8, 8'd16, '0, '0, 8'd0));
        wait_drained();
        write_hold(16'd0);
        send_item(make_op(MODE_SWEEP));
        send_item(make_op(MODE_SWEEP));
        wait_drained();
    endtask

    task automatic test_backpressure();
        out_hold = 1'b1;
        for (int i = 0; i < 12; i++) send_item(random_item(16));
        out_hold = 1'b0;
        wait_drained();
        for (int i = 0; i < 6; i++) send_item(random_item(16));
        wait_drained();
    endtask

    task automatic test_random(input int count, input logic [15:0] hold);
        write_hold(hold);
        for (int i = 0; i < count; i++) send_item(random_item(16));
        wait_drained();
    endtask

    // Result checker: one expectation per result transaction, in order.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status <= 4'd9) status_seen[out_ch.status]++;
                if (out_ch.status != want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.entry_slot != want.slot)
                    report_mismatch("entry_slot", out_ch.entry_slot, want.slot);
                if (out_ch.expired_count != want.expired)
                    report_mismatch("expired_count", out_ch.expired_count, want.expired);
                if (out_ch.removed_count != want.removed)
                    report_mismatch("removed_count", out_ch.removed_count, want.removed);
            end
        end
    end

    // Receiver: random stall bursts, or a long hold while out_hold is set.
    initial begin
        int burst;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_hold) begin
                out_ch.ready <= 1'b0;
                repeat (3 * SCAN_CYCLES) @(negedge i_clk);
                out_ch.ready <= 1'b1;
                while (out_hold) @(negedge i_clk);
            end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 7);
                out_ch.ready <= 1'b0;
                repeat (burst) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #400ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_NONE;
        in_ch.prefix_high = '0;
        in_ch.prefix_low = '0;
        in_ch.prefix_length = '0;
        in_ch.route_metric = '0;
        in_ch.source_high = '0;
        in_ch.source_low = '0;
        in_ch.arrival_port = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        now_ticks = '0;
        hold_ticks = RTU_HOLD_RESET;
        for (int i = 0; i < 16; i++) begin
            known_ph[i] = {8'($urandom_range(0, 254)), 56'(rand64())};
            known_pl[i] = (i < 4) ? 64'd0 : rand64();
            known_len[i] = (i == 0) ? 8'd128 : 8'($urandom_range(0, 128));
        end
        for (int i = 0; i < 4; i++) begin
            known_sh[i] = rand64();
            known_sl[i] = rand64();
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_routes();
        test_aging(16'd1, 12);
        test_aging(16'd0, 3);
        test_table_full();
        test_backpressure();
        test_random(530, 16'd2);
        test_random(500, 16'd65535);
        test_random(350, 16'd5);
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        test_random(150, RTU_HOLD_RESET);

        $display("Sent %0d transactions and checked %0d results over hold times 0 to 65535.",
                 items_sent, result_count);
        $display("Outcomes: installed %0d, refreshed %0d, improved %0d, poisoned %0d, full %0d.",
                 status_seen[ST_INSTALLED], status_seen[ST_REFRESHED],
                 status_seen[ST_IMPROVED], status_seen[ST_POISONED], status_seen[ST_FULL]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: ripng_route_table_update_core.f
design/rtu_pkg.sv
design/rtu_ifs.sv
design/rtu_front.sv
design/rtu_back.sv
design/ripng_route_table_update_core.sv
tb/sv/ripng_route_table_update_core_tb.sv
